[sv/query_param_percent_decoder_core_defines.svh]
// ----------------------------------------------------------------------------
// query_param_percent_decoder_core_defines
// assertion macros used by the decoder rtl
// ----------------------------------------------------------------------------
`ifndef QUERY_PARAM_PERCENT_DECODER_CORE_DEFINES_SVH
`define QUERY_PARAM_PERCENT_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define QPD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define QPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QPD_ASSERT_SAME(lbl, ante, cons, msg)
`define QPD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[sv/qpd_pkg.sv]
// ----------------------------------------------------------------------------
// qpd_pkg
// types and constants of the query parameter percent decoder
// ----------------------------------------------------------------------------
package qpd_pkg;

    localparam int unsigned LEN_W = 16;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;

    localparam logic [LEN_W-1:0] BUF_SIZE_RESET = 16'd1024;
    localparam logic [LEN_W:0]   CAP_MARGIN     = 17'd3;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_FINAL = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [3:0] {
        PH_NORMAL = 4'b0001,
        PH_HIGH   = 4'b0010,
        PH_LOW    = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic       action;
        logic [7:0] in_char;
    } item_t;

    typedef struct packed {
        logic             kind;
        logic [7:0]       out_byte;
        logic             status;
        logic [LEN_W-1:0] decoded_length;
    } result_t;

    // bit 4 flags a hex digit, bits 3:0 carry its value
    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [7:0] d;
        d = 8'h00;
        priority if (ch >= 8'h30 && ch <= 8'h39)
        begin
            d = ch - 8'h30;
            return {1'b1, d[3:0]};
        end
        else if (ch >= 8'h41 && ch <= 8'h46)
        begin
            d = ch - 8'h37;
            return {1'b1, d[3:0]};
        end
        else if (ch >= 8'h61 && ch <= 8'h66)
        begin
            d = ch - 8'h57;
            return {1'b1, d[3:0]};
        end
        else
        begin
            return 5'b0_0000;
        end
    endfunction

endpackage

[sv/qpd_if.sv]
// ----------------------------------------------------------------------------
// qpd_if
// valid/ready channels of the query parameter percent decoder
// ----------------------------------------------------------------------------
interface qpd_item_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] in_char;

    modport source (output valid, output action, output in_char, input ready);
    modport sink   (input valid, input action, input in_char, output ready);
endinterface

interface qpd_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  out_byte;
    logic        status;
    logic [15:0] decoded_length;

    modport source (output valid, output kind, output out_byte, output status,
                    output decoded_length, input ready);
    modport sink   (input valid, input kind, input out_byte, input status,
                    input decoded_length, output ready);
endinterface

interface qpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/qpd_in_stage.sv]
// ----------------------------------------------------------------------------
// qpd_in_stage
// input register holding one character transaction for the decode step
// ----------------------------------------------------------------------------
module qpd_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  qpd_pkg::item_t in_item,
    input  logic           advance,
    output logic           item_valid,
    output qpd_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    qpd_pkg::item_t item_reg;
    logic           accept;

    assign in_ready = !valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[sv/qpd_decode.sv]
// ----------------------------------------------------------------------------
// qpd_decode
// per character decode step with phase, pending nibble and byte count
// ----------------------------------------------------------------------------
`include "query_param_percent_decoder_core_defines.svh"

module qpd_decode
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  qpd_pkg::item_t                 item,
    input  logic [qpd_pkg::LEN_W-1:0]      buffer_size,
    output logic                           res_valid,
    output qpd_pkg::result_t               res
);

    qpd_pkg::phase_t             phase_reg;
    qpd_pkg::phase_t             phase_next;
    logic [3:0]                  nibble_reg;
    logic [3:0]                  nibble_next;
    logic [qpd_pkg::LEN_W-1:0]   count_reg;
    logic [qpd_pkg::LEN_W-1:0]   count_next;

    logic       term;
    logic       cap_fail;
    logic [4:0] hex;
    logic       err;

    assign term     = item.action || (item.in_char == qpd_pkg::CHAR_NUL)
                      || (item.in_char == qpd_pkg::CHAR_AMP);
    assign cap_fail = ({1'b0, count_reg} + qpd_pkg::CAP_MARGIN) >= {1'b0, buffer_size};
    assign hex      = qpd_pkg::hex_decode(item.in_char);

    always_comb
    begin
        phase_next  = phase_reg;
        nibble_next = nibble_reg;
        count_next  = count_reg;
        res_valid   = 1'b0;
        res         = '0;
        err         = 1'b0;

        if (fire)
        begin
            unique case (phase_reg)
                qpd_pkg::PH_DONE:
                begin
                    if (item.action)
                    begin
                        phase_next  = qpd_pkg::PH_NORMAL;
                        nibble_next = 4'h0;
                        count_next  = '0;
                    end
                end
                qpd_pkg::PH_HIGH, qpd_pkg::PH_LOW:
                begin
                    if (item.action || !hex[4])
                    begin
                        res_valid        = 1'b1;
                        res.kind         = qpd_pkg::KIND_FINAL;
                        res.status       = qpd_pkg::STATUS_ERR;
                        phase_next       = item.action ? qpd_pkg::PH_NORMAL
                                                       : qpd_pkg::PH_DONE;
                        nibble_next      = 4'h0;
                        count_next       = '0;
                    end
                    else if (phase_reg == qpd_pkg::PH_HIGH)
                    begin
                        nibble_next = hex[3:0];
                        phase_next  = qpd_pkg::PH_LOW;
                    end
                    else
                    begin
                        res_valid    = 1'b1;
                        res.kind     = qpd_pkg::KIND_BYTE;
                        res.out_byte = {nibble_reg, hex[3:0]};
                        phase_next   = qpd_pkg::PH_NORMAL;
                        nibble_next  = 4'h0;
                        count_next   = count_reg + 1'b1;
                    end
                end
                qpd_pkg::PH_NORMAL:
                begin
                    if (term || cap_fail)
                    begin
                        err                = term ? (buffer_size == '0) : 1'b1;
                        res_valid          = 1'b1;
                        res.kind           = qpd_pkg::KIND_FINAL;
                        res.status         = err ? qpd_pkg::STATUS_ERR : qpd_pkg::STATUS_OK;
                        res.decoded_length = err ? '0 : count_reg;
                        phase_next         = (term && item.action) ? qpd_pkg::PH_NORMAL
                                                                   : qpd_pkg::PH_DONE;
                        nibble_next        = 4'h0;
                        count_next         = '0;
                    end
                    else if (item.in_char == qpd_pkg::CHAR_PCT)
                    begin
                        phase_next = qpd_pkg::PH_HIGH;
                    end
                    else
                    begin
                        res_valid    = 1'b1;
                        res.kind     = qpd_pkg::KIND_BYTE;
                        res.out_byte = (item.in_char == qpd_pkg::CHAR_PLUS)
                                       ? qpd_pkg::CHAR_SPACE : item.in_char;
                        count_next   = count_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next  = qpd_pkg::PH_NORMAL;
                    nibble_next = 4'h0;
                    count_next  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= qpd_pkg::PH_NORMAL;
            nibble_reg <= 4'h0;
            count_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            nibble_reg <= nibble_next;
            count_reg  <= count_next;
        end
    end

    `QPD_ASSERT_SAME(a_done_silent, fire && (phase_reg == qpd_pkg::PH_DONE), !res_valid, "result while finished")
    `QPD_ASSERT_SAME(a_marker_final, fire && item.action && (phase_reg != qpd_pkg::PH_DONE), res_valid && (res.kind == qpd_pkg::KIND_FINAL), "end marker gave no final")
    `QPD_ASSERT_NEXT(a_marker_restart, fire && item.action, (phase_reg == qpd_pkg::PH_NORMAL) && (count_reg == '0), "end marker did not restart")
    `QPD_ASSERT_SAME(a_nibble_idle, phase_reg == qpd_pkg::PH_NORMAL, nibble_reg == 4'h0, "stale nibble in normal phase")

endmodule

[sv/qpd_out_stage.sv]
// ----------------------------------------------------------------------------
// qpd_out_stage
// result register toward the downstream channel
// ----------------------------------------------------------------------------
module qpd_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  qpd_pkg::result_t res,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output qpd_pkg::result_t out_res
);

    logic             valid_reg;
    logic             valid_next;
    qpd_pkg::result_t res_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

[sv/query_param_percent_decoder_core.sv]
// ----------------------------------------------------------------------------
// query_param_percent_decoder_core
// form-urlencoded query value decoder, one character transaction per cycle
// while the output stage is free or being emptied by the receiver
// a character is held in the input stage register, then decoded, and its
// result is held in the output stage register toward the receiver
// the decode step updates phase, pending nibble and byte count
// reset: async active low, buffer size 1024, fresh value, both stages empty
// ----------------------------------------------------------------------------
module query_param_percent_decoder_core
(
    input  logic         clk,
    input  logic         rst_n,
    qpd_cfg_if.sink      cfg,
    qpd_item_if.sink     src,
    qpd_result_if.source dst
);

    logic [qpd_pkg::LEN_W-1:0] buffer_size_reg;

    qpd_pkg::item_t   in_item;
    qpd_pkg::item_t   item;
    logic             item_valid;
    logic             advance;
    logic             out_free;
    logic             res_valid;
    qpd_pkg::result_t res;
    qpd_pkg::result_t out_res;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_size_reg <= qpd_pkg::BUF_SIZE_RESET;
        end
        else if (cfg.valid)
        begin
            buffer_size_reg <= cfg.data;
        end
    end

    assign in_item.action  = src.action;
    assign in_item.in_char = src.in_char;
    assign advance         = item_valid && out_free;

    qpd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (src.valid),
        .in_ready   (src.ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    qpd_decode u_decode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .item        (item),
        .buffer_size (buffer_size_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    qpd_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .free      (out_free),
        .out_valid (dst.valid),
        .out_ready (dst.ready),
        .out_res   (out_res)
    );

    assign dst.kind           = out_res.kind;
    assign dst.out_byte       = out_res.out_byte;
    assign dst.status         = out_res.status;
    assign dst.decoded_length = out_res.decoded_length;

endmodule

[tb/query_param_percent_decoder_core_tb.sv]
// ----------------------------------------------------------------------------
// query_param_percent_decoder_core_tb
// Self-checking bench for the query value percent decoder. A scoreboard
// class tracks the decoder's phase, the pending nibble, the byte count and
// the buffer size, and predicts every decoded byte and final status. The
// stimulus is a short directed value set followed by random well-formed
// values with noise and broken escapes, run under several buffer sizes
// and three patterns of sender and receiver stalls, the last with none.
// ----------------------------------------------------------------------------
module query_param_percent_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 200000;
    localparam int CHARS_PER_SIZE = 208;

    class percent_decode_scoreboard;
        logic [15:0]      buf_size;
        qpd_pkg::phase_t  ph;
        logic [3:0]       high_nibble;
        logic [15:0]      byte_count;
        qpd_pkg::result_t expected_results [$];
        int unsigned      mismatches;
        int unsigned      bytes_checked;
        int unsigned      finals_checked;
        int unsigned      error_finals;

        function new();
            buf_size       = qpd_pkg::BUF_SIZE_RESET;
            mismatches     = 0;
            bytes_checked  = 0;
            finals_checked = 0;
            error_finals   = 0;
            fresh_value();
        endfunction

        static function logic [4:0] hex_digit(logic [7:0] ch);
            if (ch >= "0" && ch <= "9")
                return {1'b1, 4'(ch - "0")};
            else if (ch >= "A" && ch <= "F")
                return {1'b1, 4'(ch - "A" + 8'd10)};
            else if (ch >= "a" && ch <= "f")
                return {1'b1, 4'(ch - "a" + 8'd10)};
            return 5'b0_0000;
        endfunction

        function void set_size(logic [15:0] v);
            buf_size = v;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void fresh_value();
            ph          = qpd_pkg::PH_NORMAL;
            high_nibble = 4'h0;
            byte_count  = 16'd0;
        endfunction

        function void push_byte(logic [7:0] b);
            qpd_pkg::result_t r;
            r.kind           = qpd_pkg::KIND_BYTE;
            r.out_byte       = b;
            r.status         = qpd_pkg::STATUS_OK;
            r.decoded_length = 16'd0;
            byte_count       = byte_count + 16'd1;
            expected_results.push_back(r);
        endfunction

        function void finish_value(logic by_marker, logic err);
            qpd_pkg::result_t r;
            r.kind           = qpd_pkg::KIND_FINAL;
            r.out_byte       = 8'h00;
            r.status         = err ? qpd_pkg::STATUS_ERR : qpd_pkg::STATUS_OK;
            r.decoded_length = err ? 16'd0 : byte_count;
            fresh_value();
            if (!by_marker)
                ph = qpd_pkg::PH_DONE;
            expected_results.push_back(r);
        endfunction

        function void note_char(logic act, logic [7:0] ch);
            logic       term;
            logic [4:0] dig;
            term = act || ch == qpd_pkg::CHAR_NUL || ch == qpd_pkg::CHAR_AMP;
            case (ph)
                qpd_pkg::PH_DONE:
                begin
                    if (act)
                        fresh_value();
                end
                qpd_pkg::PH_HIGH, qpd_pkg::PH_LOW:
                begin
                    dig = act ? 5'b0_0000 : hex_digit(ch);
                    if (!dig[4])
                        finish_value(act, 1'b1);
                    else if (ph == qpd_pkg::PH_HIGH)
                    begin
                        high_nibble = dig[3:0];
                        ph          = qpd_pkg::PH_LOW;
                    end
                    else
                    begin
                        ph = qpd_pkg::PH_NORMAL;
                        push_byte({high_nibble, dig[3:0]});
                        high_nibble = 4'h0;
                    end
                end
                default:
                begin
                    if (term)
                        finish_value(act, buf_size == 16'd0);
                    else if (int'(byte_count) + 3 >= int'(buf_size))
                        finish_value(1'b0, 1'b1);
                    else if (ch == qpd_pkg::CHAR_PCT)
                        ph = qpd_pkg::PH_HIGH;
                    else
                        push_byte(ch == qpd_pkg::CHAR_PLUS ? qpd_pkg::CHAR_SPACE : ch);
                end
            endcase
        endfunction

        function void check_result(qpd_pkg::result_t got);
            qpd_pkg::result_t exp;
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected: kind %0d byte %02h status %0d length %0d",
                       got.kind, got.out_byte, got.status, got.decoded_length);
                mismatches++;
                return;
            end
            exp = expected_results.pop_front();
            if (got.kind !== exp.kind)
            begin
                $error("kind: expected %0d, got %0d", exp.kind, got.kind);
                mismatches++;
            end
            if (got.out_byte !== exp.out_byte)
            begin
                $error("out_byte: expected %02h, got %02h", exp.out_byte, got.out_byte);
                mismatches++;
            end
            if (got.status !== exp.status)
            begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                mismatches++;
            end
            if (got.decoded_length !== exp.decoded_length)
            begin
                $error("decoded_length: expected %0d, got %0d",
                       exp.decoded_length, got.decoded_length);
                mismatches++;
            end
            if (exp.kind == qpd_pkg::KIND_FINAL)
            begin
                finals_checked++;
                if (exp.status == qpd_pkg::STATUS_ERR)
                    error_finals++;
            end
            else
                bytes_checked++;
        endfunction
    endclass

    logic clk;
    logic rst_n;

    qpd_cfg_if    cfg_bus();
    qpd_item_if   char_bus();
    qpd_result_if res_bus();

    percent_decode_scoreboard sb = new();

    int src_idle_pct = 23;
    int dst_idle_pct = 46;
    int chars_sent   = 0;
    int sizes_written = 0;
    int cycle_count  = 0;

    query_param_percent_decoder_core u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .src   (char_bus),
        .dst   (res_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= LIMIT_CYCLES)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // result side: random stalls and checking
    initial
    begin
        qpd_pkg::result_t got;
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_bus.valid && res_bus.ready)
            begin
                got.kind           = res_bus.kind;
                got.out_byte       = res_bus.out_byte;
                got.status         = res_bus.status;
                got.decoded_length = res_bus.decoded_length;
                sb.check_result(got);
            end
            res_bus.ready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10)
            return 8'("0" + v);
        return $urandom_range(1) ? 8'("A" + v - 10) : 8'("a" + v - 10);
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (percent_decode_scoreboard::hex_digit(c) != 5'b0_0000);
        return c;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = ($urandom_range(4) == 0) ? 8'($urandom_range(1, 255))
                                         : 8'($urandom_range(33, 126));
        while (c == qpd_pkg::CHAR_PCT || c == qpd_pkg::CHAR_AMP || c == qpd_pkg::CHAR_PLUS);
        return c;
    endfunction

    task automatic send_char(input logic act, input logic [7:0] ch);
        while ($urandom_range(99) < src_idle_pct)
        begin
            char_bus.valid <= 1'b0;
            @(posedge clk);
        end
        char_bus.valid   <= 1'b1;
        char_bus.action  <= act;
        char_bus.in_char <= ch;
        @(posedge clk);
        while (!char_bus.ready)
            @(posedge clk);
        sb.note_char(act, ch);
        chars_sent++;
    endtask

    task automatic drain_results();
        char_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_size(input logic [15:0] v);
        drain_results();
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= v;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        cfg_bus.valid <= 1'b0;
        sb.set_size(v);
        sizes_written++;
    endtask

    task automatic send_value();
        int len;
        int pick;
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
        repeat (len)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                send_char(1'b0, plain_char());
            else if (pick < 70)
                send_char(1'b0, qpd_pkg::CHAR_PLUS);
            else if (pick < 92)
            begin
                send_char(1'b0, qpd_pkg::CHAR_PCT);
                send_char(1'b0, hex_char());
                send_char(1'b0, hex_char());
            end
            else if (pick < 96)
            begin
                send_char(1'b0, qpd_pkg::CHAR_PCT);
                if ($urandom_range(1))
                    send_char(1'b0, hex_char());
                send_char(1'b0, non_hex_char());
            end
            else
                send_char(1'b0, 8'($urandom_range(255)));
        end
        pick = $urandom_range(99);
        if (pick < 45)
            send_char(1'b1, 8'($urandom_range(255)));
        else
        begin
            send_char(1'b0, (pick < 85) ? qpd_pkg::CHAR_AMP : qpd_pkg::CHAR_NUL);
            repeat ($urandom_range(3))
                send_char(1'b0, 8'($urandom_range(255)));
            send_char(1'b1, 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        int          phase_start;
        bit          paused;
        logic [15:0] size_plan [9];

        rst_n            <= 1'b0;
        char_bus.valid   <= 1'b0;
        char_bus.action  <= 1'b0;
        char_bus.in_char <= 8'h00;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.data     <= 16'd0;
        size_plan = '{16'd16, 16'd0, 16'd65535, 16'd4, 16'd1024, 16'd3,
                      16'($urandom_range(65535)), 16'd1, 16'd2};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plus, escapes in both cases, extreme bytes, ampersand end
        send_char(1'b0, "a");
        send_char(1'b0, qpd_pkg::CHAR_PLUS);
        send_char(1'b0, qpd_pkg::CHAR_PCT);
        send_char(1'b0, "4");
        send_char(1'b0, "1");
        send_char(1'b0, qpd_pkg::CHAR_PCT);
        send_char(1'b0, "f");
        send_char(1'b0, "F");
        send_char(1'b0, qpd_pkg::CHAR_PCT);
        send_char(1'b0, "0");
        send_char(1'b0, "0");
        send_char(1'b0, 8'hFF);
        send_char(1'b0, qpd_pkg::CHAR_AMP);
        // ignored until end marker
        send_char(1'b0, "x");
        send_char(1'b1, 8'h00);
        // bad escape digit
        send_char(1'b0, qpd_pkg::CHAR_PCT);
        send_char(1'b0, "G");
        send_char(1'b1, 8'hFF);
        // end marker inside an escape
        send_char(1'b0, qpd_pkg::CHAR_PCT);
        send_char(1'b0, "4");
        send_char(1'b1, 8'h00);
        // end marker and zero byte in normal phase
        send_char(1'b0, "b");
        send_char(1'b1, 8'h00);
        send_char(1'b0, qpd_pkg::CHAR_NUL);
        send_char(1'b1, 8'h00);

        for (int r = 0; r < 3; r++)
        begin
            src_idle_pct = (r == 0) ? 23 : (r == 1) ? 46 : 0;
            dst_idle_pct = (r == 0) ? 46 : (r == 1) ? 23 : 0;
            for (int s = 0; s < 3; s++)
            begin
                write_size(size_plan[r * 3 + s]);
                phase_start = chars_sent;
                paused      = 1'b0;
                while (chars_sent - phase_start < CHARS_PER_SIZE)
                begin
                    send_value();
                    if (!paused && chars_sent - phase_start >= CHARS_PER_SIZE / 2)
                    begin
                        drain_results();
                        paused = 1'b1;
                    end
                end
            end
        end

        drain_results();
        $display("covered %0d character transactions under %0d buffer size writes",
                 chars_sent, sizes_written);
        $display("checked %0d decoded bytes and %0d final results (%0d errors)",
                 sb.bytes_checked, sb.finals_checked, sb.error_finals);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
